// ----- rtl/smeu_pkg.sv -----
// package for the stack machine execute unit
// opcodes, error and status codes, state machine type, shared widths, multiply/divide command and response types
package smeu_pkg;
   localparam int WORD_BITS  = 32;
   localparam int DATA_DEPTH = 256;
   localparam int CALL_DEPTH = 64;
   localparam int PROG_DEPTH = 1024;
   localparam int DA_BITS = $clog2(DATA_DEPTH);
   localparam int DD_BITS = $clog2(DATA_DEPTH + 1);
   localparam int CA_BITS = $clog2(CALL_DEPTH);
   localparam int CD_BITS = $clog2(CALL_DEPTH + 1);
   localparam int PC_BITS = $clog2(PROG_DEPTH);
   localparam int CNT_BITS = $clog2(WORD_BITS + 1);

   localparam logic [4:0] OP_BEGIN = 5'd0;
   localparam logic [4:0] OP_END   = 5'd1;
   localparam logic [4:0] OP_PUSH  = 5'd2;
   localparam logic [4:0] OP_POP   = 5'd3;
   localparam logic [4:0] OP_PUSHR = 5'd4;
   localparam logic [4:0] OP_POPR  = 5'd5;
   localparam logic [4:0] OP_ADD   = 5'd6;
   localparam logic [4:0] OP_SUB   = 5'd7;
   localparam logic [4:0] OP_MUL   = 5'd8;
   localparam logic [4:0] OP_DIV   = 5'd9;
   localparam logic [4:0] OP_IN    = 5'd10;
   localparam logic [4:0] OP_OUT   = 5'd11;
   localparam logic [4:0] OP_JMP   = 5'd12;
   localparam logic [4:0] OP_JEQ   = 5'd13;
   localparam logic [4:0] OP_JNE   = 5'd14;
   localparam logic [4:0] OP_JA    = 5'd15;
   localparam logic [4:0] OP_JAE   = 5'd16;
   localparam logic [4:0] OP_JB    = 5'd17;
   localparam logic [4:0] OP_JBE   = 5'd18;
   localparam logic [4:0] OP_CALL  = 5'd19;
   localparam logic [4:0] OP_RET   = 5'd20;

   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_UNDER = 3'd1;
   localparam logic [2:0] ERR_OVER  = 3'd2;
   localparam logic [2:0] ERR_DIVZ  = 3'd3;
   localparam logic [2:0] ERR_CALL  = 3'd4;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE, S_RD1, S_RD2, S_EXEC, S_ITER, S_WB, S_OUT
   } seq_state_type;

   typedef struct packed {
      logic                 start;
      logic                 is_mul;
      logic [WORD_BITS-1:0] a;
      logic [WORD_BITS-1:0] b;
   } alu_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [WORD_BITS-1:0] res;
   } alu_rsp_type;
endpackage

// ----- rtl/smeu_muldiv.sv -----
// iterative multiply and signed divide unit, one bit per cycle
// depends on smeu_pkg
module smeu_muldiv (
   input  logic                 clock,
   input  logic                 reset,
   input  smeu_pkg::alu_cmd_type cmd,
   output smeu_pkg::alu_rsp_type rsp
);
   import smeu_pkg::*;

   logic [WORD_BITS-1:0] acc_ff, acc_in;   // product or remainder
   logic [WORD_BITS-1:0] q_ff, q_in;       // multiplier or quotient
   logic [WORD_BITS-1:0] b_ff, b_in;
   logic                 mul_ff, mul_in, neg_ff, neg_in, busy_ff, busy_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [WORD_BITS:0]   trial;
   logic [WORD_BITS-1:0] ma, mb, qres;

   always_comb begin
      ma = cmd.a[WORD_BITS-1] ? (~cmd.a + 1'b1) : cmd.a;
      mb = cmd.b[WORD_BITS-1] ? (~cmd.b + 1'b1) : cmd.b;
      trial = {acc_ff, q_ff[WORD_BITS-1]} - {1'b0, b_ff};
      acc_in = acc_ff; q_in = q_ff; b_in = b_ff; mul_in = mul_ff;
      neg_in = neg_ff; busy_in = busy_ff; cnt_in = cnt_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in = CNT_BITS'(WORD_BITS);
         mul_in = cmd.is_mul;
         acc_in = '0;
         q_in = cmd.is_mul ? cmd.b : ma;
         b_in = cmd.is_mul ? cmd.a : mb;
         neg_in = cmd.a[WORD_BITS-1] ^ cmd.b[WORD_BITS-1];
      end else if (busy_ff) begin
         // result held from the done cycle on
         if (cnt_ff == '0) busy_in = 1'b0;
         else begin
            cnt_in = cnt_ff - 1'b1;
            if (mul_ff) begin
               // shift-add, low bits only
               acc_in = {acc_ff[WORD_BITS-2:0], 1'b0} + (q_ff[WORD_BITS-1] ? b_ff : '0);
               q_in = {q_ff[WORD_BITS-2:0], 1'b0};
            end else if (!trial[WORD_BITS]) begin
               acc_in = trial[WORD_BITS-1:0];
               q_in = {q_ff[WORD_BITS-2:0], 1'b1};
            end else begin
               acc_in = {acc_ff[WORD_BITS-2:0], q_ff[WORD_BITS-1]};
               q_in = {q_ff[WORD_BITS-2:0], 1'b0};
            end
         end
      end
      qres = neg_ff ? (~q_ff + 1'b1) : q_ff;
      rsp.done = busy_ff && (cnt_ff == '0);
      rsp.res = mul_ff ? acc_ff : qres;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in; q_ff <= q_in; b_ff <= b_in;
      mul_ff <= mul_in; neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ----- rtl/stack_machine_execute_unit_core.sv -----
// stack machine execute unit: one decoded instruction per request beat
// One request beat carries an instruction; one response beat returns the next
// index, jump flag, out value, run status and error code. The data stack and
// call stack are memories with registered reads; four registers are flops.
// The request is registered, then passes the states read top, read second,
// execute and write back before the response beat is valid; mul and div
// also iterate in the one-bit-per-cycle shared multiply/divide unit.
// One instruction is in flight at a time: req_tready is low from acceptance
// until the state machine is back in idle after the response beat is taken.
// The response is held in an output register until rsp_tready; the block
// waits meanwhile. Reset clears status, depths and registers; stack
// memories are not cleared, and entries at or above the current depth are never used.
// Underflow, overflow, zero divisor and call stack faults report an error
// and leave state unchanged.
module stack_machine_execute_unit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_type[4:0], imm_value[36:5], reg_index[38:37], target_index[48:39],
   // own_index[58:49], in_value[90:59], zero fill to 96
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // next_index[9:0], jumped[10], out_valid[11], out_value[43:12],
   // run_status[45:44], error_code[48:46], zero fill to 56
   output logic [55:0] rsp_tdata
);
   import smeu_pkg::*;

   seq_state_type st_ff, st_in;
   logic [95:0] ins_ff, ins_in;
   logic [4:0]  op;
   logic [WORD_BITS-1:0] imm, inv;
   logic [1:0]  ri;
   logic [PC_BITS-1:0] tgt, own, nxt;

   logic [WORD_BITS-1:0] dmem [DATA_DEPTH];
   logic [PC_BITS+DD_BITS-1:0] cmem [CALL_DEPTH];
   logic [WORD_BITS-1:0] rd_ff, top_ff, top_in, sec_ff, sec_in;
   logic [PC_BITS+DD_BITS-1:0] crd_ff;
   logic [DA_BITS-1:0] raddr;
   logic dwe; logic [DA_BITS-1:0] dwa; logic [WORD_BITS-1:0] dwd;
   logic cwe;

   logic [1:0] status_ff, status_in;
   logic [DD_BITS-1:0] dep_ff, dep_in;
   logic [CD_BITS-1:0] cdep_ff, cdep_in;
   logic [WORD_BITS-1:0] gpr_ff [4];
   logic [WORD_BITS-1:0] gpr_in [4];
   logic [55:0] out_ff, out_in;
   logic ov_ff, ov_in;

   alu_cmd_type acmd; alu_rsp_type arsp;
   smeu_muldiv u_md (.clock(clock), .reset(reset), .cmd(acmd), .rsp(arsp));

   assign op  = ins_ff[4:0];
   assign imm = WORD_BITS'($signed(ins_ff[36:5]));
   assign ri  = ins_ff[38:37];
   assign tgt = ins_ff[48:39];
   assign own = ins_ff[58:49];
   assign inv = WORD_BITS'($signed(ins_ff[90:59]));
   assign nxt = own + 1'b1;
   assign req_tready = (st_ff == S_IDLE) && !ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = out_ff;

   function automatic logic [55:0] pack(logic [PC_BITS-1:0] n, logic j, logic v,
                                        logic [WORD_BITS-1:0] val, logic [1:0] s,
                                        logic [2:0] e);
      return {7'd0, e, s, val[31:0], v, j, n};
   endfunction

   logic two_ok, one_ok, eq, lt_lo_hi, lt_hi_lo, c;
   logic [WORD_BITS-1:0] res;
   logic [DD_BITS-1:0] sdep;

   always_comb begin
      st_in = st_ff; ins_in = ins_ff; top_in = top_ff; sec_in = sec_ff;
      status_in = status_ff; dep_in = dep_ff; cdep_in = cdep_ff;
      for (int i = 0; i < 4; i++) gpr_in[i] = gpr_ff[i];
      out_in = out_ff; ov_in = ov_ff && !rsp_tready;
      raddr = DA_BITS'(dep_ff - 1'b1);
      dwe = 1'b0; dwa = DA_BITS'(dep_ff); dwd = imm; cwe = 1'b0;
      acmd = '0; acmd.a = top_ff; acmd.b = sec_ff; acmd.is_mul = (op == OP_MUL);
      two_ok = dep_ff >= DD_BITS'(2); one_ok = dep_ff != '0;
      eq = top_ff == sec_ff;
      lt_lo_hi = $signed(sec_ff) < $signed(top_ff);
      lt_hi_lo = $signed(top_ff) < $signed(sec_ff);
      c = 1'b0; res = '0; sdep = crd_ff[DD_BITS-1:0];
      unique case (st_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               ins_in = req_tdata;
               st_in = S_RD1;
            end
         end
         S_RD1: begin
            // top entry read issued here, second below
            raddr = DA_BITS'(dep_ff - 1'b1);
            st_in = S_RD2;
         end
         S_RD2: begin
            raddr = DA_BITS'(dep_ff - DD_BITS'(2));
            top_in = rd_ff;
            st_in = S_EXEC;
         end
         S_EXEC: begin
            st_in = S_OUT;
            if ((op == OP_MUL || op == OP_DIV) && status_ff == ST_RUN && two_ok
                && !(op == OP_DIV && rd_ff == '0)) begin
               sec_in = rd_ff;
               acmd.b = rd_ff;
               acmd.start = 1'b1;
               st_in = S_ITER;
            end else begin
               sec_in = rd_ff;
               st_in = S_WB;
            end
         end
         S_ITER: begin
            if (arsp.done) st_in = S_WB;
         end
         S_WB: begin
            st_in = S_OUT;
            ov_in = 1'b1;
            out_in = pack(nxt, 1'b0, 1'b0, '0, status_ff, ERR_NONE);
            if (status_ff != ST_RUN) begin
               if (op == OP_BEGIN && status_ff == ST_IDLE) status_in = ST_RUN;
               out_in = pack(nxt, 1'b0, 1'b0, '0, status_in, ERR_NONE);
            end else begin
               priority if (op == OP_END) begin
                  status_in = ST_DONE;
                  out_in = pack(nxt, 1'b0, 1'b0, '0, ST_DONE, ERR_NONE);
               end else if (op == OP_PUSH || op == OP_PUSHR || op == OP_IN) begin
                  if (dep_ff >= DD_BITS'(DATA_DEPTH))
                     out_in = pack(nxt, 1'b0, 1'b0, '0, status_ff, ERR_OVER);
                  else begin
                     dwe = 1'b1;
                     dwd = (op == OP_PUSH) ? imm : (op == OP_PUSHR) ? gpr_ff[ri] : inv;
                     dep_in = dep_ff + 1'b1;
                  end
               end else if (op == OP_POP || op == OP_POPR) begin
                  if (!one_ok) out_in = pack(nxt, 1'b0, 1'b0, '0, status_ff, ERR_UNDER);
                  else begin
                     dep_in = dep_ff - 1'b1;
                     if (op == OP_POPR) gpr_in[ri] = top_ff;
                  end
               end else if (op >= OP_ADD && op <= OP_DIV) begin
                  if (!two_ok) out_in = pack(nxt, 1'b0, 1'b0, '0, status_ff, ERR_UNDER);
                  else if (op == OP_DIV && sec_ff == '0)
                     out_in = pack(nxt, 1'b0, 1'b0, '0, status_ff, ERR_DIVZ);
                  else begin
                     res = (op == OP_ADD) ? top_ff + sec_ff :
                           (op == OP_SUB) ? top_ff - sec_ff : arsp.res;
                     dwe = 1'b1;
                     dwa = DA_BITS'(dep_ff - DD_BITS'(2));
                     dwd = res;
                     dep_in = dep_ff - 1'b1;
                  end
               end else if (op == OP_OUT) begin
                  if (!one_ok) out_in = pack(nxt, 1'b0, 1'b0, '0, status_ff, ERR_UNDER);
                  else out_in = pack(nxt, 1'b0, 1'b1, top_ff, status_ff, ERR_NONE);
               end else if (op == OP_JMP) begin
                  out_in = pack(tgt, 1'b1, 1'b0, '0, status_ff, ERR_NONE);
               end else if (op >= OP_JEQ && op <= OP_JBE) begin
                  unique case (op)
                     OP_JEQ: c = eq;
                     OP_JNE: c = !eq;
                     OP_JA:  c = lt_lo_hi;
                     OP_JAE: c = lt_lo_hi || eq;
                     OP_JB:  c = lt_hi_lo;
                     default: c = lt_hi_lo || eq;
                  endcase
                  if (!two_ok) out_in = pack(nxt, 1'b0, 1'b0, '0, status_ff, ERR_UNDER);
                  else out_in = pack(c ? tgt : nxt, c, 1'b0, '0, status_ff, ERR_NONE);
               end else if (op == OP_CALL) begin
                  if (cdep_ff >= CD_BITS'(CALL_DEPTH))
                     out_in = pack(nxt, 1'b0, 1'b0, '0, status_ff, ERR_CALL);
                  else begin
                     cwe = 1'b1;
                     cdep_in = cdep_ff + 1'b1;
                     out_in = pack(tgt, 1'b1, 1'b0, '0, status_ff, ERR_NONE);
                  end
               end else if (op == OP_RET) begin
                  if (cdep_ff == '0)
                     out_in = pack(nxt, 1'b0, 1'b0, '0, status_ff, ERR_CALL);
                  else begin
                     cdep_in = cdep_ff - 1'b1;
                     if (dep_ff > sdep) dep_in = sdep;
                     out_in = pack(crd_ff[PC_BITS+DD_BITS-1:DD_BITS], 1'b1, 1'b0, '0,
                                   status_ff, ERR_NONE);
                  end
               end else begin
               end
            end
         end
         S_OUT: begin
            if (!ov_ff) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_ff <= dmem[raddr];
      crd_ff <= cmem[CA_BITS'(cdep_ff - 1'b1)];
      if (dwe) dmem[dwa] <= dwd;
      if (cwe) cmem[CA_BITS'(cdep_ff)] <= {nxt, dep_ff};
      ins_ff <= ins_in; top_ff <= top_in; sec_ff <= sec_in; out_ff <= out_in;
      if (reset) begin
         st_ff <= S_IDLE; ov_ff <= 1'b0; status_ff <= ST_IDLE;
         dep_ff <= '0; cdep_ff <= '0;
         for (int i = 0; i < 4; i++) gpr_ff[i] <= '0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in; status_ff <= status_in;
         dep_ff <= dep_in; cdep_ff <= cdep_in;
         for (int i = 0; i < 4; i++) gpr_ff[i] <= gpr_in[i];
      end
   end

   a_depth: assert property (@(posedge clock) disable iff (reset)
      dep_ff <= DD_BITS'(DATA_DEPTH)) else $error("data depth beyond stack");
   a_cdepth: assert property (@(posedge clock) disable iff (reset)
      cdep_ff <= CD_BITS'(CALL_DEPTH)) else $error("call depth beyond stack");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accept while response pending");
   a_status: assert property (@(posedge clock) disable iff (reset)
      ($past(status_ff) == ST_DONE && !$past(reset)) |-> status_ff == ST_DONE)
      else $error("left ended state");
endmodule
